/* rtl/bctm_pkg.sv */
// Shared types and constants for the BCD calendar to milliseconds unit.
// No dependencies.
package bctm_pkg;

    localparam int PRESC_W    = 15;
    localparam int DIV_W      = PRESC_W + 1;
    localparam int NUM_W      = 25;
    localparam int QUO_W      = 10;
    localparam int MS_W       = 42;
    localparam int DAYS_W     = 17;
    localparam int VAL_W      = 7;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 48;
    localparam logic [PRESC_W-1:0] PRESC_RESET = 15'd255;
    localparam logic [9:0]         MS_PER_SEC  = 10'd1000;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DIV_W-1:0] div;
        logic [MS_W-1:0]  seconds;
        logic             bad;
    } cell_data_t;

    function automatic logic [8:0] cum_days(input logic [3:0] passed);
        logic [8:0] r;
        case (passed)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd365;
        endcase
        return r;
    endfunction

endpackage

/* rtl/bcd_calendar_to_milliseconds_unit.sv */
// Top level of the BCD calendar to milliseconds unit.
// Depends on bctm_pkg, bctm_front, bctm_div_cell, bctm_back.
//
// Usage:
//   s_ side takes one calendar snapshot request per cycle (tvalid/tready).
//   m_ side returns one result per request, in order.
//   cfg_wr_en/cfg_wr_data load the sync prescaler (reset value 255); write
//   it only while no request is in flight.
// Pipeline: two front stages, ten divider cells settling one quotient bit
//   each, one output stage.
// Throughput: one request per cycle while m_tready stays high; the divider
//   cell chain is fully pipelined.
// Reset: all stages empty, prescaler back to 255.
// Stall: each stage holds while the next is full and stalled; empty stages keep filling,
//   so s_tready drops only once the whole chain is full.
// Invalid flag: sub-second count above prescaler, month 0 or above 12, or
//   year 0.
module bcd_calendar_to_milliseconds_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bctm_pkg::PRESC_W-1:0]   cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // subsecond_count[15:0], seconds_bcd[22:16], minutes_bcd[29:23],
    // hours_bcd[35:30], day_bcd[41:36], month_bcd[46:42], year_bcd[54:47]
    input  logic [bctm_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // total_milliseconds[41:0], invalid[42]
    output logic [bctm_pkg::M_DATA_W-1:0]  m_tdata
);
    import bctm_pkg::*;

    logic [PRESC_W-1:0] presc_reg;
    logic               cv [QUO_W+1];
    logic               cr [QUO_W+1];
    cell_data_t         cd [QUO_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presc_reg <= PRESC_RESET;
        end else if (cfg_wr_en) begin
            presc_reg <= cfg_wr_data;
        end
    end

    bctm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .prescaler (presc_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        bctm_div_cell #(.SHIFT(QUO_W - 1 - i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_data  (cd[i+1])
        );
    end

    bctm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cv[QUO_W]),
        .in_ready  (cr[QUO_W]),
        .in_data   (cd[QUO_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("chain empty at output but input stalled");
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready) else $error("ready did not propagate through chain");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("result present after reset");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_DATA_W-1:MS_W+1] == '0)) else $error("pad bits set");

endmodule

/* rtl/bctm_front.sv */
// Front end: BCD decode, day count and divider numerator, then seconds count.
// Depends on bctm_pkg.
module bctm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [bctm_pkg::PRESC_W-1:0]   prescaler,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bctm_pkg::S_DATA_W-1:0]  in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bctm_pkg::cell_data_t           out_data
);
    import bctm_pkg::*;

    logic               v1_reg, v2_reg;
    logic               rdy1, rdy2;
    logic [VAL_W-1:0]   sec_reg, min_reg, hour_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic               under_reg, bad_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DIV_W-1:0]   div_reg;
    cell_data_t         data2_reg, data2_next;

    logic [15:0]        ssr;
    logic [VAL_W-1:0]   sec, mnt, hour, day;
    logic [4:0]         month;
    logic [7:0]         year, past;
    logic [3:0]         passed;
    logic [8:0]         dbm;
    logic [DAYS_W-1:0]  days_next;
    logic               under;
    logic [NUM_W-1:0]   num_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        ssr   = in_data[15:0];
        sec   = VAL_W'(in_data[19:16]) + VAL_W'(in_data[22:20]) * VAL_W'(10);
        mnt   = VAL_W'(in_data[26:23]) + VAL_W'(in_data[29:27]) * VAL_W'(10);
        hour  = VAL_W'(in_data[33:30]) + VAL_W'(in_data[35:34]) * VAL_W'(10);
        day   = VAL_W'(in_data[39:36]) + VAL_W'(in_data[41:40]) * VAL_W'(10);
        month = 5'(in_data[45:42]) + (in_data[46] ? 5'd10 : 5'd0);
        year  = 8'(in_data[50:47]) + 8'(in_data[54:51]) * 8'd10;
        past  = (year == 8'd0) ? 8'd0 : year - 8'd1;
        if (month == 5'd0) begin
            passed = 4'd0;
        end else if (month > 5'd12) begin
            passed = 4'd12;
        end else begin
            passed = 4'(month - 5'd1);
        end
        dbm = cum_days(passed) + 9'((passed >= 4'd2) && (year[1:0] == 2'd0));
        days_next = DAYS_W'(day) + DAYS_W'(dbm) + DAYS_W'(past) * DAYS_W'(365)
                  + DAYS_W'(past[7:2]);
        under    = ssr > 16'(prescaler);
        num_next = under ? '0
                 : NUM_W'(prescaler - ssr[PRESC_W-1:0]) * NUM_W'(MS_PER_SEC);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= in_valid;
        end
        if (rdy1 && in_valid) begin
            sec_reg   <= sec;
            min_reg   <= mnt;
            hour_reg  <= hour;
            days_reg  <= days_next;
            under_reg <= under;
            bad_reg   <= under || (month == 5'd0) || (month > 5'd12) || (year == 8'd0);
            num_reg   <= num_next;
            div_reg   <= DIV_W'(prescaler) + DIV_W'(1);
        end
    end

    always_comb begin
        data2_next.rem     = num_reg;
        data2_next.quo     = '0;
        data2_next.div     = div_reg;
        data2_next.bad     = bad_reg;
        data2_next.seconds = MS_W'(sec_reg) + MS_W'(min_reg) * MS_W'(60)
                           + MS_W'(hour_reg) * MS_W'(3600)
                           + MS_W'(days_reg) * MS_W'(86400) - MS_W'(under_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            data2_reg <= data2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = data2_reg;

endmodule

/* rtl/bctm_div_cell.sv */
// One restoring-division cell: settles one quotient bit and passes on.
// Depends on bctm_pkg.
module bctm_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bctm_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bctm_pkg::cell_data_t out_data
);
    import bctm_pkg::*;

    logic        valid_reg;
    cell_data_t  data_reg, data_next;
    logic [NUM_W+1:0] trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = in_data;
        trial = {2'b00, in_data.rem} - ((NUM_W+2)'(in_data.div) << SHIFT);
        if (!trial[NUM_W+1]) begin
            data_next.rem        = trial[NUM_W-1:0];
            data_next.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* rtl/bctm_back.sv */
// Output stage: seconds to milliseconds plus the divided fraction.
// Depends on bctm_pkg.
module bctm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bctm_pkg::cell_data_t           in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bctm_pkg::M_DATA_W-1:0]  out_data
);
    import bctm_pkg::*;

    logic              valid_reg;
    logic [MS_W-1:0]   total_reg, total_next;
    logic              bad_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign total_next = in_data.seconds * MS_W'(MS_PER_SEC) + MS_W'(in_data.quo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            total_reg <= total_next;
            bad_reg   <= in_data.bad;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {(M_DATA_W-MS_W-1)'(0), bad_reg, total_reg};

endmodule
